// ===== hw/rtl/smap_pkg.sv =====
package smap_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_NOT_SUCCESS = 2'd0;
    localparam logic [1:0] STATUS_NO_ADDRESS  = 2'd1;
    localparam logic [1:0] STATUS_FOUND       = 2'd2;

    // Message constants
    localparam logic [15:0] BINDING_SUCCESS    = 16'h0101;
    localparam logic [15:0] ATTR_XOR_MAPPED    = 16'h0020;
    localparam logic [4:0]  HEADER_BYTES       = 5'd20;
    localparam logic [4:0]  TYPE_BYTES         = 5'd2;
    localparam logic [4:0]  ATTR_HDR_LAST      = 5'd3;
    localparam logic [4:0]  ADDR_FIRST         = 5'd4;
    localparam logic [4:0]  ADDR_LAST          = 5'd7;
    localparam logic [15:0] ADDR_MIN_LENGTH    = 16'd8;

    // Magic cookie byte for address byte index 0..3
    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] result;
        case (idx)
            2'd0:    result = 8'h21;
            2'd1:    result = 8'h12;
            2'd2:    result = 8'hA4;
            default: result = 8'h42;
        endcase
        return result;
    endfunction

endpackage

// ===== hw/rtl/stun_mapped_address_parser_core.sv =====
// Parses a received STUN reply presented one byte per beat, first byte first, with
// i_last_byte marking the final byte. Bytes stream in back to back with no gaps
// between messages; one result beat (status and the unmasked XOR-MAPPED-ADDRESS
// IPv4 address) appears from a single output register in the cycle after the
// marked byte is accepted. Only a final byte that arrives while an earlier result
// is still stalled at the output is held back; all other bytes are accepted
// regardless of the output side.
module stun_mapped_address_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_public_address
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ATTR_HDR,
        PH_ADDR,
        PH_SKIP,
        PH_IGNORE
    } t_phase;

    localparam logic [4:0] POS_MAX = 5'h1F;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [15:0] r_rtype, n_rtype;
    logic [15:0] r_atype, n_atype;
    logic [15:0] r_rem, n_rem;
    logic [31:0] r_addr, n_addr;
    logic        r_found, n_found;

    logic        r_out_valid;
    logic [1:0]  r_status, n_status;
    logic [31:0] r_public_address, n_public_address;

    logic [4:0]  w_pos_inc;
    logic [15:0] w_len;
    logic [16:0] w_padded;
    logic [16:0] w_padded_m1;
    logic        w_in_acc;
    logic        w_success;

    // Hold a final byte only while the previous result is stuck at the output
    assign o_in_stall = r_out_valid && i_out_stall && i_last_byte;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Attribute length as it completes with this byte, padded to a multiple of four
    assign w_pos_inc   = r_pos + 5'd1;
    assign w_len       = {r_rem[7:0], i_data_byte};
    assign w_padded    = ({1'b0, w_len} + 17'd3) & ~17'd3;
    assign w_padded_m1 = w_padded - 17'd1;

    // Advance the parser by one byte
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_rtype = r_rtype;
        n_atype = r_atype;
        n_rem   = r_rem;
        n_addr  = r_addr;
        n_found = r_found;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_pos < smap_pkg::TYPE_BYTES) begin
                    n_rtype = {r_rtype[7:0], i_data_byte};
                end
                n_pos = w_pos_inc;
                if (w_pos_inc == smap_pkg::TYPE_BYTES
                    && n_rtype != smap_pkg::BINDING_SUCCESS) begin
                    n_phase = PH_IGNORE;
                end else if (w_pos_inc >= smap_pkg::HEADER_BYTES) begin
                    n_phase = PH_ATTR_HDR;
                    n_pos   = '0;
                end
            end
            PH_ATTR_HDR: begin
                if (r_pos < smap_pkg::TYPE_BYTES) begin
                    n_atype = {r_atype[7:0], i_data_byte};
                end else begin
                    n_rem = w_len;
                end
                n_pos = w_pos_inc;
                if (r_pos == smap_pkg::ATTR_HDR_LAST) begin
                    n_pos = '0;
                    if (w_len == 16'd0) begin
                        n_phase = PH_ATTR_HDR;
                    end else begin
                        // length check uses the unpadded value
                        n_rem   = w_padded_m1[15:0];
                        n_phase = (n_atype == smap_pkg::ATTR_XOR_MAPPED && !r_found
                                   && w_len >= smap_pkg::ADDR_MIN_LENGTH)
                                  ? PH_ADDR : PH_SKIP;
                    end
                end
            end
            PH_ADDR, PH_SKIP: begin
                if (r_phase == PH_ADDR && r_pos >= smap_pkg::ADDR_FIRST
                    && r_pos <= smap_pkg::ADDR_LAST) begin
                    n_addr = {r_addr[23:0], i_data_byte ^ smap_pkg::cookie_byte(r_pos[1:0])};
                    if (r_pos == smap_pkg::ADDR_LAST) begin
                        n_found = 1'b1;
                    end
                end
                if (r_rem == 16'd0) begin
                    n_phase = PH_ATTR_HDR;
                    n_pos   = '0;
                end else begin
                    n_rem = r_rem - 16'd1;
                    if (r_pos != POS_MAX) begin
                        n_pos = w_pos_inc;
                    end
                end
            end
            PH_IGNORE: begin
                n_phase = PH_IGNORE;
            end
            default: begin
                n_phase = PH_IGNORE;
            end
        endcase
    end

    // Form the result from the state after this byte
    assign w_success = n_rtype == smap_pkg::BINDING_SUCCESS
                       && !(n_phase == PH_HEADER && n_pos < smap_pkg::TYPE_BYTES)
                       && n_phase != PH_IGNORE;

    always_comb begin
        n_status         = smap_pkg::STATUS_NOT_SUCCESS;
        n_public_address = '0;
        if (w_success && n_found) begin
            n_status         = smap_pkg::STATUS_FOUND;
            n_public_address = n_addr;
        end else if (w_success) begin
            n_status = smap_pkg::STATUS_NO_ADDRESS;
        end
    end

    // Hold parser state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HEADER;
            r_pos            <= '0;
            r_rtype          <= '0;
            r_atype          <= '0;
            r_rem            <= '0;
            r_addr           <= '0;
            r_found          <= 1'b0;
            r_out_valid      <= 1'b0;
            r_status         <= smap_pkg::STATUS_NOT_SUCCESS;
            r_public_address <= '0;
        end else begin
            if (w_in_acc) begin
                if (i_last_byte) begin
                    r_phase <= PH_HEADER;
                    r_pos   <= '0;
                    r_rtype <= '0;
                    r_atype <= '0;
                    r_rem   <= '0;
                    r_addr  <= '0;
                    r_found <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_pos   <= n_pos;
                    r_rtype <= n_rtype;
                    r_atype <= n_atype;
                    r_rem   <= n_rem;
                    r_addr  <= n_addr;
                    r_found <= n_found;
                end
            end
            if (w_in_acc && i_last_byte) begin
                r_out_valid      <= 1'b1;
                r_status         <= n_status;
                r_public_address <= n_public_address;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_public_address = r_public_address;

endmodule

// ===== hw/rtl/smap_checker.sv =====
module smap_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_last_byte,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_public_address
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_public_address))
        else $error("stalled result beat changed");

    // Address is zero unless one was found
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != smap_pkg::STATUS_FOUND |-> o_public_address == 32'd0)
        else $error("address present without found status");

    // Final byte gives a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_byte |=> o_out_valid)
        else $error("no result after final byte");

    // Other bytes give no result, unless an earlier result is still stalled
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_last_byte && !(o_out_valid && i_out_stall)
            |=> !o_out_valid)
        else $error("result without final byte");

endmodule

bind stun_mapped_address_parser_core smap_checker u_smap_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_last_byte      (i_last_byte),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_public_address (o_public_address)
);
